[design/assert_macros.svh]
// Assertion macros shared by the blitter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Flag cond whenever it holds
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

[design/nnsb_pkg.sv]
// Package: types, constants and codes of the nearest-neighbor scaling blitter
package nnsb_pkg;

    localparam int WINDOW_WIDTH   = 960;
    localparam int WINDOW_HEIGHT  = 720;
    localparam int WINDOW_LEFT    = 160;
    localparam int MAX_SOURCE_DIM = 512;

    localparam int COL_W    = 10;
    localparam int ROW_W    = 10;
    localparam int DCOL_W   = 11;
    localparam int DIM_W    = 10;
    localparam int PITCH_W  = 14;
    localparam int OFFSET_W = 22;
    localparam int PIXEL_W  = 32;
    localparam int PROD_W   = COL_W + DIM_W;

    // col*width/960 = ((col*width) >> 6) / 15; /15 by reciprocal 17477 >> 18
    localparam int DIV_X_PRE  = 6;
    localparam int DIV_X_MULT = 17477;
    localparam int DIV_X_POST = 18;
    // row*height/720 = ((row*height) >> 4) / 45; /45 by reciprocal 46604 >> 21
    localparam int DIV_Y_PRE  = 4;
    localparam int DIV_Y_MULT = 46604;
    localparam int DIV_Y_POST = 21;

    typedef enum logic [1:0] {
        FMT_0RGB1555 = 2'd0,
        FMT_XRGB8888 = 2'd1,
        FMT_RGB565   = 2'd2
    } pixel_format_t;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_ROW_PITCH     = 2'd2,
        REG_PIXEL_FORMAT  = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MULT = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0]   source_width;
        logic [DIM_W-1:0]   source_height;
        logic [PITCH_W-1:0] row_pitch;
        logic [1:0]         pixel_format;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mult;
        logic divide;
        logic emit;
    } cmd_t;

endpackage

[design/nnsb_regs.sv]
// Configuration register file on the APB-style port
module nnsb_regs
    import nnsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= DIM_W'(256);
            cfg_reg.source_height <= DIM_W'(224);
            cfg_reg.row_pitch     <= PITCH_W'(512);
            cfg_reg.pixel_format  <= FMT_0RGB1555;
        end
        else if (wr_en)
        begin
            case (index)
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= pwdata[DIM_W-1:0];
                REG_ROW_PITCH:     cfg_reg.row_pitch     <= pwdata[PITCH_W-1:0];
                REG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= pwdata[1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SOURCE_WIDTH:  prdata = 32'(cfg_reg.source_width);
            REG_SOURCE_HEIGHT: prdata = 32'(cfg_reg.source_height);
            REG_ROW_PITCH:     prdata = 32'(cfg_reg.row_pitch);
            REG_PIXEL_FORMAT:  prdata = 32'(cfg_reg.pixel_format);
            default:           prdata = 32'd0;
        endcase
    end

endmodule

[design/nnsb_ctrl.sv]
// Controller: sequences accept, multiply, divide and emit of one word
`include "assert_macros.svh"

module nnsb_ctrl
    import nnsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    output logic pixel_ready,
    output logic result_valid,
    input  logic result_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign pixel_ready  = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = pixel_valid && (state_reg == ST_IDLE);
        cmd.mult   = (state_reg == ST_MULT);
        cmd.divide = (state_reg == ST_DIV);
        cmd.emit   = (state_reg == ST_SUM) && (!out_valid_reg || result_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd.load) state_next = ST_MULT;
            ST_MULT: state_next = ST_DIV;
            ST_DIV:  state_next = ST_SUM;
            ST_SUM:  if (cmd.emit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_CLK(a_state_onehot, $onehot(state_reg), "controller state not one-hot")
    `ASSERT_CLK(a_load_starts, cmd.load |=> (state_reg == ST_MULT), "accept did not start multiply")
    `ASSERT_NEVER(a_emit_overwrite, cmd.emit && out_valid_reg && !result_ready, "word overwritten")

endmodule

[design/nnsb_dp.sv]
// Datapath: pixel conversion, window counters and fetch offset arithmetic
`include "assert_macros.svh"

module nnsb_dp
    import nnsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  cfg_t                cfg,
    input  logic [PIXEL_W-1:0]  raw_pixel,
    output logic [PIXEL_W-1:0]  rgba_pixel,
    output logic [DCOL_W-1:0]   dest_column,
    output logic [ROW_W-1:0]    dest_row,
    output logic [OFFSET_W-1:0] next_fetch_offset,
    output logic                frame_done
);

    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(WINDOW_WIDTH - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(WINDOW_HEIGHT - 1);
    localparam logic [DCOL_W-1:0] LEFT     = DCOL_W'(WINDOW_LEFT);

    function automatic logic [7:0] widen5(logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [PIXEL_W-1:0] convert(logic [PIXEL_W-1:0] p, logic [1:0] fmt);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (fmt)
            FMT_XRGB8888:
            begin
                r = p[23:16];
                g = p[15:8];
                b = p[7:0];
            end
            FMT_0RGB1555:
            begin
                r = widen5(p[14:10]);
                g = widen5(p[9:5]);
                b = widen5(p[4:0]);
            end
            default:
            begin
                r = widen5(p[15:11]);
                g = {p[10:5], p[10:9]};
                b = widen5(p[4:0]);
            end
        endcase
        return {8'hFF, b, g, r};
    endfunction

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                last_col;
    logic                last_pix;

    logic [PIXEL_W-1:0]  pixel_hold_reg;
    logic [DCOL_W-1:0]   col_hold_reg;
    logic [ROW_W-1:0]    row_hold_reg;
    logic                done_hold_reg;

    logic [PROD_W-1:0]   prod_x_reg;
    logic [PROD_W-1:0]   prod_y_reg;
    logic [31:0]         recip_x;
    logic [31:0]         recip_y;
    logic [COL_W-1:0]    qx_reg;
    logic [DIM_W-1:0]    qy_reg;

    logic [DIM_W+PITCH_W-1:0] y_term;
    logic [DIM_W+1:0]         x_term;
    logic [OFFSET_W-1:0]      offset_next;

    logic [PIXEL_W-1:0]  rgba_reg;
    logic [DCOL_W-1:0]   dcol_reg;
    logic [ROW_W-1:0]    drow_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                done_reg;

    assign last_col = (col_reg == LAST_COL);
    assign last_pix = last_col && (row_reg == LAST_ROW);

    // advance the window position on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_pix ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign recip_x = 32'(prod_x_reg >> DIV_X_PRE) * 32'(DIV_X_MULT);
    assign recip_y = 32'(prod_y_reg >> DIV_Y_PRE) * 32'(DIV_Y_MULT);

    assign y_term = (DIM_W+PITCH_W)'(qy_reg) * (DIM_W+PITCH_W)'(cfg.row_pitch);
    assign x_term = (cfg.pixel_format == FMT_XRGB8888) ? {qx_reg, 2'b00}
                                                       : {1'b0, qx_reg, 1'b0};
    assign offset_next = OFFSET_W'(y_term) + OFFSET_W'(x_term);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pixel_hold_reg <= convert(raw_pixel, cfg.pixel_format);
            col_hold_reg   <= DCOL_W'(col_reg) + LEFT;
            row_hold_reg   <= row_reg;
            done_hold_reg  <= last_pix;
        end
        if (cmd.mult)
        begin
            prod_x_reg <= PROD_W'(col_reg) * PROD_W'(cfg.source_width);
            prod_y_reg <= PROD_W'(row_reg) * PROD_W'(cfg.source_height);
        end
        if (cmd.divide)
        begin
            qx_reg <= COL_W'(recip_x >> DIV_X_POST);
            qy_reg <= DIM_W'(recip_y >> DIV_Y_POST);
        end
        if (cmd.emit)
        begin
            rgba_reg   <= pixel_hold_reg;
            dcol_reg   <= col_hold_reg;
            drow_reg   <= row_hold_reg;
            offset_reg <= offset_next;
            done_reg   <= done_hold_reg;
        end
    end

    assign rgba_pixel        = rgba_reg;
    assign dest_column       = dcol_reg;
    assign dest_row          = drow_reg;
    assign next_fetch_offset = offset_reg;
    assign frame_done        = done_reg;

    `ASSERT_CLK(a_col_range, col_reg <= LAST_COL, "window column out of range")
    `ASSERT_CLK(a_row_range, row_reg <= LAST_ROW, "window row out of range")
    `ASSERT_CLK(a_wrap_origin, (cmd.load && last_pix) |=> (col_reg == '0 && row_reg == '0),
                "frame end did not wrap to origin")

endmodule

[design/nearest_neighbor_scaling_blitter.sv]
// A result word passes the multiply, reciprocal divide and offset sum steps
// of the offset datapath in that order after its input word is accepted; these
// work on one word at a time, so no new word is taken until the sum step emits.
// An input word is taken while the previous result still waits on its output.
// Reset (rst_n low, async): window at column 0 row 0, no result pending,
// registers at width 256, height 224, pitch 512, format 0RGB1555.
module nearest_neighbor_scaling_blitter
    import nnsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  logic [PIXEL_W-1:0]  raw_pixel,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [PIXEL_W-1:0]  rgba_pixel,
    output logic [DCOL_W-1:0]   dest_column,
    output logic [ROW_W-1:0]    dest_row,
    output logic [OFFSET_W-1:0] next_fetch_offset,
    output logic                frame_done
);

    cfg_t cfg;
    cmd_t cmd;

    nnsb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nnsb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    nnsb_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .raw_pixel         (raw_pixel),
        .rgba_pixel        (rgba_pixel),
        .dest_column       (dest_column),
        .dest_row          (dest_row),
        .next_fetch_offset (next_fetch_offset),
        .frame_done        (frame_done)
    );

endmodule
